@@ rtl/crg_pkg.sv @@
// ============================================================================
// crg_pkg: shared constants, types and helpers of the camera ray generator
// Fixed-point formats, lane vector types, register indexes and the rounding
// and clamping helpers used along the datapath.
// ============================================================================
package crg_pkg;

    // Fixed-point formats
    localparam int DIR_FRAC_BITS = 14;
    localparam int POS_FRAC_BITS = 8;
    localparam int FIELD_W       = 16;

    // Normalizer widths
    localparam int NORM_W   = 40;                       // signed lane entering a normalizer
    localparam int NORM_TOP = 30;                       // leading bit after normalization
    localparam int MAG_W    = NORM_TOP + 1;             // normalized magnitude
    localparam int SQ_W     = 64;                       // sum of squares
    localparam int ROOT_W   = 32;                       // integer square root
    localparam int QUO_W    = DIR_FRAC_BITS + 1;        // quotient, at most one in Q1.14
    localparam int NUM_W    = MAG_W + DIR_FRAC_BITS + 1;// dividend with rounding term

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [31:0] PLANE_SCALE_RESET = 32'h006A_006A;

    typedef logic [2:0][NORM_W-1:0]  norm_vec_t;
    typedef logic [2:0][FIELD_W-1:0] dir_vec_t;
    typedef logic [2:0][MAG_W-1:0]   mag_vec_t;
    typedef logic [2:0][QUO_W-1:0]   quo_vec_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAMERA_MODE      = 3'd0,
        REG_LENS_BLUR_ENABLE = 3'd1,
        REG_CAMERA_POSITION  = 3'd2,
        REG_FORWARD_VECTOR   = 3'd3,
        REG_RIGHT_VECTOR     = 3'd4,
        REG_UP_VECTOR        = 3'd5,
        REG_PLANE_SCALE      = 3'd6,
        REG_FOCUS_SETTING    = 3'd7
    } cfg_index_t;

    // Round to nearest, halves away from zero, dropping s fraction bits (s > 0)
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
        logic [63:0] mag_v;
        logic [63:0] half;
        mag_v = v[63] ? 64'(-v) : 64'(v);
        half  = 64'(1) << (s - 1);
        mag_v = (mag_v + half) >> s;
        return v[63] ? -$signed(mag_v) : $signed(mag_v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7FFF;
        else if (v < -64'sd32768)
            return 16'sh8000;
        else
            return 16'(v);
    endfunction

endpackage

@@ rtl/camera_ray_generator_top.sv @@
// ============================================================================
// camera_ray_generator_top: one camera ray per image-plane sample
// Pinhole, thin-lens and orthographic ray setup in fixed point, fully
// pipelined at one ray per clock while the output is not stalled.
// ============================================================================
// Usage:
//   Configuration: write registers over cfg_valid/cfg_ready with cfg_index
//   and cfg_data; cfg_ready is always high. Write only while no request is
//   in flight.
//   Input: one request per in_valid/in_ready handshake carries plane_x,
//   plane_y and the lens sample, all Q1.14.
//   Output: one ray per request over out_valid/out_ready, origin in Q8.8
//   and unit heading in Q1.14, in request order.
//   Throughput: one request per clock while the output is not stalled. The
//   two normalizers in series each hold a 32-stage square root and a
//   16-stage divider.
//   Stall: all stages advance together; while a ray waits at the output
//   the pipeline holds and in_ready drops, so nothing is lost or repeated.
//   Reset: every stage is emptied and the registers take their reset
//   values (plane scale 0x006A006A, everything else zero).
// ============================================================================
module camera_ray_generator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [crg_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [15:0]                   plane_x,
    input  logic signed [15:0]                   plane_y,
    input  logic signed [15:0]                   lens_sample_x,
    input  logic signed [15:0]                   lens_sample_y,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [15:0]                   origin_x,
    output logic signed [15:0]                   origin_y,
    output logic signed [15:0]                   origin_z,
    output logic signed [15:0]                   heading_x,
    output logic signed [15:0]                   heading_y,
    output logic signed [15:0]                   heading_z
);
    import crg_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        camera_mode_reg;
    logic        lens_blur_enable_reg;
    logic [47:0] camera_position_reg;
    logic [47:0] forward_vector_reg;
    logic [47:0] right_vector_reg;
    logic [47:0] up_vector_reg;
    logic [31:0] plane_scale_reg;
    logic [31:0] focus_setting_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_mode_reg      <= 1'b0;
            lens_blur_enable_reg <= 1'b0;
            camera_position_reg  <= '0;
            forward_vector_reg   <= '0;
            right_vector_reg     <= '0;
            up_vector_reg        <= '0;
            plane_scale_reg      <= PLANE_SCALE_RESET;
            focus_setting_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CAMERA_MODE:      camera_mode_reg      <= cfg_data[0];
                REG_LENS_BLUR_ENABLE: lens_blur_enable_reg <= cfg_data[0];
                REG_CAMERA_POSITION:  camera_position_reg  <= cfg_data;
                REG_FORWARD_VECTOR:   forward_vector_reg   <= cfg_data;
                REG_RIGHT_VECTOR:     right_vector_reg     <= cfg_data;
                REG_UP_VECTOR:        up_vector_reg        <= cfg_data;
                REG_PLANE_SCALE:      plane_scale_reg      <= cfg_data[31:0];
                REG_FOCUS_SETTING:    focus_setting_reg    <= cfg_data[31:0];
            endcase
        end
    end

    // Unpacked views of the registers; the user must change them only while
    // idle, which the block does not enforce, so every stage reads them directly.
    logic signed [15:0] pos_v [3];
    logic signed [15:0] fwd_v [3];
    logic signed [15:0] rgt_v [3];
    logic signed [15:0] upv_v [3];
    logic signed [15:0] scale_h;
    logic signed [15:0] scale_v;
    logic signed [15:0] focus_dist;
    logic signed [15:0] blur_k;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_v[i] = $signed(camera_position_reg[16*i +: 16]);
            fwd_v[i] = $signed(forward_vector_reg[16*i +: 16]);
            rgt_v[i] = $signed(right_vector_reg[16*i +: 16]);
            upv_v[i] = $signed(up_vector_reg[16*i +: 16]);
        end
    end

    assign scale_h    = $signed(plane_scale_reg[15:0]);
    assign scale_v    = $signed(plane_scale_reg[31:16]);
    assign focus_dist = $signed(focus_setting_reg[15:0]);
    assign blur_k     = $signed(focus_setting_reg[31:16]);

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together whenever the output
    // register is empty or being drained.
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // ------------------------------------------------------------------
    // Stage 1: scale the image-plane point and the lens sample
    // ------------------------------------------------------------------
    logic               st1_valid_reg;
    logic signed [31:0] xs_reg;
    logic signed [31:0] ys_reg;
    logic signed [31:0] bxk_reg;
    logic signed [31:0] byk_reg;

    // ------------------------------------------------------------------
    // Stage 2: round the scaled terms to the formats each mode needs
    // ------------------------------------------------------------------
    logic               st2_valid_reg;
    logic signed [23:0] xwp_reg;   // pinhole, Q1.14
    logic signed [23:0] ywp_reg;
    logic signed [17:0] xwo_reg;   // orthographic, Q8.8
    logic signed [17:0] ywo_reg;
    logic signed [17:0] ox_reg;    // lens offset, Q8.8
    logic signed [17:0] oy_reg;

    // ------------------------------------------------------------------
    // Stage 3: scale the basis vectors
    // ------------------------------------------------------------------
    logic               st3_valid_reg;
    logic signed [39:0] rxp_reg [3];
    logic signed [39:0] uyp_reg [3];
    logic signed [39:0] rxo_reg [3];
    logic signed [39:0] uyo_reg [3];
    logic signed [39:0] rox_reg [3];
    logic signed [39:0] uoy_reg [3];

    // ------------------------------------------------------------------
    // Stage 4: sum the ray direction and pick the origin
    // ------------------------------------------------------------------
    logic               st4_valid_reg;
    norm_vec_t          tmp1_reg;
    norm_vec_t          lensoff_reg;
    dir_vec_t           org_reg;
    logic signed [39:0] tmp1_next [3];
    logic signed [39:0] fo_next [3];
    logic signed [39:0] orth_next [3];
    dir_vec_t           org_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tmp1_next[i] = (40'(fwd_v[i]) <<< DIR_FRAC_BITS) + rxp_reg[i] + uyp_reg[i];
            fo_next[i]   = (40'(pos_v[i]) <<< DIR_FRAC_BITS) + rox_reg[i] + uoy_reg[i];
            orth_next[i] = (40'(pos_v[i]) <<< DIR_FRAC_BITS) + rxo_reg[i] + uyo_reg[i];
            if (camera_mode_reg)
                org_next[i] = sat16(rnd_shift(64'(orth_next[i]), DIR_FRAC_BITS));
            else if (lens_blur_enable_reg)
                org_next[i] = sat16(rnd_shift(64'(fo_next[i]), DIR_FRAC_BITS));
            else
                org_next[i] = pos_v[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st1_valid_reg <= in_valid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xs_reg  <= 32'(plane_x) * 32'(scale_h);
            ys_reg  <= 32'(plane_y) * 32'(scale_v);
            bxk_reg <= 32'(lens_sample_x) * 32'(blur_k);
            byk_reg <= 32'(lens_sample_y) * 32'(blur_k);

            xwp_reg <= 24'(rnd_shift(64'(xs_reg), POS_FRAC_BITS));
            ywp_reg <= 24'(rnd_shift(64'(ys_reg), POS_FRAC_BITS));
            xwo_reg <= 18'(rnd_shift(64'(xs_reg), DIR_FRAC_BITS));
            ywo_reg <= 18'(rnd_shift(64'(ys_reg), DIR_FRAC_BITS));
            ox_reg  <= 18'(rnd_shift(64'(bxk_reg), DIR_FRAC_BITS));
            oy_reg  <= 18'(rnd_shift(64'(byk_reg), DIR_FRAC_BITS));

            for (int i = 0; i < 3; i++)
            begin
                rxp_reg[i] <= 40'(rgt_v[i]) * 40'(xwp_reg);
                uyp_reg[i] <= 40'(upv_v[i]) * 40'(ywp_reg);
                rxo_reg[i] <= 40'(rgt_v[i]) * 40'(xwo_reg);
                uyo_reg[i] <= 40'(upv_v[i]) * 40'(ywo_reg);
                rox_reg[i] <= 40'(rgt_v[i]) * 40'(ox_reg);
                uoy_reg[i] <= 40'(upv_v[i]) * 40'(oy_reg);
            end

            for (int i = 0; i < 3; i++)
            begin
                tmp1_reg[i]    <= tmp1_next[i];
                lensoff_reg[i] <= rox_reg[i] + uoy_reg[i];
            end
            org_reg <= org_next;
        end
    end

    // ------------------------------------------------------------------
    // First normalizer: pinhole direction
    // ------------------------------------------------------------------
    typedef struct packed {
        norm_vec_t lensoff;
        dir_vec_t  org;
    } n1_pay_t;

    typedef struct packed {
        dir_vec_t org;
        dir_vec_t dir1;
    } n2_pay_t;

    n1_pay_t  n1_in_pay;
    logic     n1_valid;
    dir_vec_t n1_dir;
    n1_pay_t  n1_pay;

    assign n1_in_pay.lensoff = lensoff_reg;
    assign n1_in_pay.org     = org_reg;

    crg_normalize #(
        .PW ($bits(n1_pay_t))
    ) u_norm_view (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .in_valid    (st4_valid_reg),
        .in_vec      (tmp1_reg),
        .in_payload  (n1_in_pay),
        .out_valid   (n1_valid),
        .out_dir     (n1_dir),
        .out_payload (n1_pay)
    );

    // ------------------------------------------------------------------
    // Lens stages: point on the focal plane minus the shifted origin
    // ------------------------------------------------------------------
    logic               l1_valid_reg;
    logic signed [39:0] dfd_reg [3];
    norm_vec_t          l1_lensoff_reg;
    n2_pay_t            l1_pay_reg;

    logic               l2_valid_reg;
    norm_vec_t          tmp2_reg;
    n2_pay_t            l2_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            l1_valid_reg <= n1_valid;
            l2_valid_reg <= l1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
                dfd_reg[i] <= 40'($signed(n1_dir[i])) * 40'(focus_dist);
            l1_lensoff_reg  <= n1_pay.lensoff;
            l1_pay_reg.org  <= n1_pay.org;
            l1_pay_reg.dir1 <= n1_dir;

            for (int i = 0; i < 3; i++)
                tmp2_reg[i] <= dfd_reg[i] - $signed(l1_lensoff_reg[i]);
            l2_pay_reg <= l1_pay_reg;
        end
    end

    // ------------------------------------------------------------------
    // Second normalizer: thin-lens direction
    // ------------------------------------------------------------------
    logic     n2_valid;
    dir_vec_t n2_dir;
    n2_pay_t  n2_pay;

    crg_normalize #(
        .PW ($bits(n2_pay_t))
    ) u_norm_lens (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .in_valid    (l2_valid_reg),
        .in_vec      (tmp2_reg),
        .in_payload  (l2_pay_reg),
        .out_valid   (n2_valid),
        .out_dir     (n2_dir),
        .out_payload (n2_pay)
    );

    // ------------------------------------------------------------------
    // Output register: pick the heading for the mode, hold while stalled
    // ------------------------------------------------------------------
    dir_vec_t out_org_reg;
    dir_vec_t out_head_reg;
    dir_vec_t head_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (camera_mode_reg)
                head_next[i] = fwd_v[i];
            else if (lens_blur_enable_reg)
                head_next[i] = n2_dir[i];
            else
                head_next[i] = n2_pay.dir1[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= n2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_org_reg  <= n2_pay.org;
            out_head_reg <= head_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign origin_x  = $signed(out_org_reg[0]);
    assign origin_y  = $signed(out_org_reg[1]);
    assign origin_z  = $signed(out_org_reg[2]);
    assign heading_x = $signed(out_head_reg[0]);
    assign heading_y = $signed(out_head_reg[1]);
    assign heading_z = $signed(out_head_reg[2]);

`ifndef SYNTHESIS
    // A normalized pinhole or thin-lens heading never exceeds one in magnitude.
    a_heading_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !camera_mode_reg |->
                      heading_x <= 16'sd16384 && heading_x >= -16'sd16384 &&
                      heading_y <= 16'sd16384 && heading_y >= -16'sd16384 &&
                      heading_z <= 16'sd16384 && heading_z >= -16'sd16384)
        else $error("heading out of unit range");

    // Orthographic rays travel along the forward vector.
    a_ortho_heading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && camera_mode_reg |->
            out_head_reg[0] == forward_vector_reg[15:0] &&
            out_head_reg[1] == forward_vector_reg[31:16] &&
            out_head_reg[2] == forward_vector_reg[47:32])
        else $error("orthographic heading differs from forward vector");

    // A plain pinhole ray starts at the camera position.
    a_pinhole_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !camera_mode_reg && !lens_blur_enable_reg |->
            out_org_reg[0] == camera_position_reg[15:0] &&
            out_org_reg[1] == camera_position_reg[31:16] &&
            out_org_reg[2] == camera_position_reg[47:32])
        else $error("pinhole origin differs from camera position");
`endif

endmodule

@@ rtl/crg_isqrt.sv @@
// ============================================================================
// crg_isqrt: pipelined integer square root
// One result bit per stage, floor root of a 64-bit radicand, side data
// travels alongside.
// ============================================================================
module crg_isqrt #(
    parameter int PW = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [crg_pkg::SQ_W-1:0]     in_radicand,
    input  logic [PW-1:0]                in_payload,
    output logic                         out_valid,
    output logic [crg_pkg::ROOT_W-1:0]   out_root,
    output logic [PW-1:0]                out_payload
);
    import crg_pkg::*;

    localparam int STEPS = SQ_W / 2;

    logic [STEPS:0]    vld_d;
    logic [SQ_W-1:0]   rem_d [STEPS+1];
    logic [SQ_W-1:0]   res_d [STEPS+1];
    logic [PW-1:0]     pay_d [STEPS+1];

    assign vld_d[0] = in_valid;
    assign rem_d[0] = in_radicand;
    assign res_d[0] = '0;
    assign pay_d[0] = in_payload;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);

        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] rem_next;
        logic [SQ_W-1:0] res_next;
        logic [SQ_W-1:0] rem_reg;
        logic [SQ_W-1:0] res_reg;
        logic [PW-1:0]   pay_reg;
        logic            vld_reg;

        always_comb
        begin
            trial = res_d[i] + STEP_BIT;
            if (rem_d[i] >= trial)
            begin
                rem_next = rem_d[i] - trial;
                res_next = (res_d[i] >> 1) + STEP_BIT;
            end
            else
            begin
                rem_next = rem_d[i];
                res_next = res_d[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_d[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                res_reg <= res_next;
                pay_reg <= pay_d[i];
            end
        end

        assign vld_d[i+1] = vld_reg;
        assign rem_d[i+1] = rem_reg;
        assign res_d[i+1] = res_reg;
        assign pay_d[i+1] = pay_reg;
    end

    assign out_valid   = vld_d[STEPS];
    assign out_root    = res_d[STEPS][ROOT_W-1:0];
    assign out_payload = pay_d[STEPS];

endmodule

@@ rtl/crg_divider.sv @@
// ============================================================================
// crg_divider: pipelined three-lane rounding divider
// Forms round(mag * 2^DIR_FRAC_BITS / len) per lane, one quotient bit per
// stage after a setup stage; the divisor is shared by the lanes.
// ============================================================================
module crg_divider #(
    parameter int PW = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  crg_pkg::mag_vec_t           in_mag,
    input  logic [crg_pkg::ROOT_W-1:0]  in_len,
    input  logic [PW-1:0]               in_payload,
    output logic                        out_valid,
    output crg_pkg::quo_vec_t           out_quo,
    output logic [PW-1:0]               out_payload
);
    import crg_pkg::*;

    localparam int STEPS = QUO_W;

    typedef logic [2:0][NUM_W-1:0] num_vec_t;

    // Setup stage: scaled dividend plus half the divisor
    num_vec_t          prep_num_next;
    num_vec_t          prep_num_reg;
    logic [ROOT_W-1:0] prep_len_reg;
    logic [PW-1:0]     prep_pay_reg;
    logic              prep_valid_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            prep_num_next[l] = (NUM_W'(in_mag[l]) << DIR_FRAC_BITS) + NUM_W'(in_len >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (en)
            prep_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_num_reg <= prep_num_next;
            prep_len_reg <= in_len;
            prep_pay_reg <= in_payload;
        end
    end

    logic [STEPS:0]    vld_d;
    num_vec_t          rem_d [STEPS+1];
    quo_vec_t          quo_d [STEPS+1];
    logic [ROOT_W-1:0] len_d [STEPS+1];
    logic [PW-1:0]     pay_d [STEPS+1];

    assign vld_d[0] = prep_valid_reg;
    assign rem_d[0] = prep_num_reg;
    assign quo_d[0] = '0;
    assign len_d[0] = prep_len_reg;
    assign pay_d[0] = prep_pay_reg;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam int SH = STEPS - 1 - i;

        logic [NUM_W-1:0]  sub;
        num_vec_t          rem_next;
        quo_vec_t          quo_next;
        num_vec_t          rem_reg;
        quo_vec_t          quo_reg;
        logic [ROOT_W-1:0] len_reg;
        logic [PW-1:0]     pay_reg;
        logic              vld_reg;

        always_comb
        begin
            sub      = NUM_W'(len_d[i]) << SH;
            rem_next = rem_d[i];
            quo_next = quo_d[i];
            for (int l = 0; l < 3; l++)
            begin
                if (rem_d[i][l] >= sub)
                begin
                    rem_next[l]     = rem_d[i][l] - sub;
                    quo_next[l][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_d[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                len_reg <= len_d[i];
                pay_reg <= pay_d[i];
            end
        end

        assign vld_d[i+1] = vld_reg;
        assign rem_d[i+1] = rem_reg;
        assign quo_d[i+1] = quo_reg;
        assign len_d[i+1] = len_reg;
        assign pay_d[i+1] = pay_reg;
    end

    assign out_valid   = vld_d[STEPS];
    assign out_quo     = quo_d[STEPS];
    assign out_payload = pay_d[STEPS];

endmodule

@@ rtl/crg_normalize.sv @@
// ============================================================================
// crg_normalize: pipelined three-lane vector normalizer
// Scales the vector so its largest magnitude leads at bit 30, takes the
// root of the sum of squares and divides each lane by it, Q1.14 out.
// ============================================================================
module crg_normalize #(
    parameter int PW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  crg_pkg::norm_vec_t  in_vec,
    input  logic [PW-1:0]       in_payload,
    output logic                out_valid,
    output crg_pkg::dir_vec_t   out_dir,
    output logic [PW-1:0]       out_payload
);
    import crg_pkg::*;

    localparam int GROUPS = NORM_W / 8;
    localparam int LEAD_W = $clog2(NORM_W);

    typedef struct packed {
        logic [PW-1:0] user;
        mag_vec_t      mag;
        logic [2:0]    neg;
        logic          zero;
    } root_pay_t;

    typedef struct packed {
        logic [PW-1:0] user;
        logic [2:0]    neg;
        logic          zero;
    } div_pay_t;

    // ---- N1: magnitudes and combined bit mask
    norm_vec_t         n1_mag_next;
    norm_vec_t         n1_mag_reg;
    logic [NORM_W-1:0] n1_or_reg;
    logic [2:0]        n1_neg_reg;
    logic [PW-1:0]     n1_pay_reg;
    logic              n1_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n1_mag_next[i] = in_vec[i][NORM_W-1] ? NORM_W'(-in_vec[i]) : in_vec[i];
    end

    // ---- N2: per-group leading bit
    logic [GROUPS-1:0]      n2_nz_next;
    logic [GROUPS-1:0][2:0] n2_pos_next;
    logic [GROUPS-1:0]      n2_nz_reg;
    logic [GROUPS-1:0][2:0] n2_pos_reg;
    norm_vec_t              n2_mag_reg;
    logic [2:0]             n2_neg_reg;
    logic [PW-1:0]          n2_pay_reg;
    logic                   n2_valid_reg;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            n2_nz_next[g]  = |n1_or_reg[8*g +: 8];
            n2_pos_next[g] = '0;
            for (int b = 0; b < 8; b++)
                if (n1_or_reg[8*g + b])
                    n2_pos_next[g] = 3'(b);
        end
    end

    // ---- N3: leading bit of the whole mask
    logic [LEAD_W-1:0] n3_lead_next;
    logic              n3_zero_next;
    logic [LEAD_W-1:0] n3_lead_reg;
    logic              n3_zero_reg;
    norm_vec_t         n3_mag_reg;
    logic [2:0]        n3_neg_reg;
    logic [PW-1:0]     n3_pay_reg;
    logic              n3_valid_reg;

    always_comb
    begin
        n3_lead_next = '0;
        n3_zero_next = 1'b1;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (n2_nz_reg[g])
            begin
                n3_lead_next = LEAD_W'(8 * g) + LEAD_W'(n2_pos_reg[g]);
                n3_zero_next = 1'b0;
            end
        end
    end

    // ---- N4: align the leading bit to NORM_TOP, truncating dropped bits
    logic [NORM_W+NORM_TOP-1:0] n4_wide [3];
    mag_vec_t                   n4_norm_next;
    mag_vec_t                   n4_norm_reg;
    logic                       n4_zero_reg;
    logic [2:0]                 n4_neg_reg;
    logic [PW-1:0]              n4_pay_reg;
    logic                       n4_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n4_wide[i]      = {n3_mag_reg[i], {NORM_TOP{1'b0}}} >> n3_lead_reg;
            n4_norm_next[i] = n4_wide[i][MAG_W-1:0];
        end
    end

    // ---- N5: squares
    logic [2*MAG_W-1:0] n5_sq_reg [3];
    mag_vec_t           n5_norm_reg;
    logic               n5_zero_reg;
    logic [2:0]         n5_neg_reg;
    logic [PW-1:0]      n5_pay_reg;
    logic               n5_valid_reg;

    // ---- N6: sum of squares
    logic [SQ_W-1:0] n6_sum_reg;
    root_pay_t       n6_pay_reg;
    logic            n6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
            n3_valid_reg <= 1'b0;
            n4_valid_reg <= 1'b0;
            n5_valid_reg <= 1'b0;
            n6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n1_valid_reg <= in_valid;
            n2_valid_reg <= n1_valid_reg;
            n3_valid_reg <= n2_valid_reg;
            n4_valid_reg <= n3_valid_reg;
            n5_valid_reg <= n4_valid_reg;
            n6_valid_reg <= n5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_mag_reg <= n1_mag_next;
            n1_or_reg  <= n1_mag_next[0] | n1_mag_next[1] | n1_mag_next[2];
            for (int i = 0; i < 3; i++)
                n1_neg_reg[i] <= in_vec[i][NORM_W-1];
            n1_pay_reg <= in_payload;

            n2_nz_reg  <= n2_nz_next;
            n2_pos_reg <= n2_pos_next;
            n2_mag_reg <= n1_mag_reg;
            n2_neg_reg <= n1_neg_reg;
            n2_pay_reg <= n1_pay_reg;

            n3_lead_reg <= n3_lead_next;
            n3_zero_reg <= n3_zero_next;
            n3_mag_reg  <= n2_mag_reg;
            n3_neg_reg  <= n2_neg_reg;
            n3_pay_reg  <= n2_pay_reg;

            n4_norm_reg <= n4_norm_next;
            n4_zero_reg <= n3_zero_reg;
            n4_neg_reg  <= n3_neg_reg;
            n4_pay_reg  <= n3_pay_reg;

            for (int i = 0; i < 3; i++)
                n5_sq_reg[i] <= (2*MAG_W)'(n4_norm_reg[i]) * (2*MAG_W)'(n4_norm_reg[i]);
            n5_norm_reg <= n4_norm_reg;
            n5_zero_reg <= n4_zero_reg;
            n5_neg_reg  <= n4_neg_reg;
            n5_pay_reg  <= n4_pay_reg;

            n6_sum_reg      <= SQ_W'(n5_sq_reg[0]) + SQ_W'(n5_sq_reg[1]) + SQ_W'(n5_sq_reg[2]);
            n6_pay_reg.user <= n5_pay_reg;
            n6_pay_reg.mag  <= n5_norm_reg;
            n6_pay_reg.neg  <= n5_neg_reg;
            n6_pay_reg.zero <= n5_zero_reg;
        end
    end

    // ---- vector length
    logic              root_valid;
    logic [ROOT_W-1:0] root_len;
    root_pay_t         root_pay;

    crg_isqrt #(
        .PW ($bits(root_pay_t))
    ) u_isqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (n6_valid_reg),
        .in_radicand (n6_sum_reg),
        .in_payload  (n6_pay_reg),
        .out_valid   (root_valid),
        .out_root    (root_len),
        .out_payload (root_pay)
    );

    // ---- per-lane division by the length
    div_pay_t div_in_pay;
    logic     div_valid;
    quo_vec_t div_quo;
    div_pay_t div_pay;

    assign div_in_pay.user = root_pay.user;
    assign div_in_pay.neg  = root_pay.neg;
    assign div_in_pay.zero = root_pay.zero;

    crg_divider #(
        .PW ($bits(div_pay_t))
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (root_valid),
        .in_mag      (root_pay.mag),
        .in_len      (root_len),
        .in_payload  (div_in_pay),
        .out_valid   (div_valid),
        .out_quo     (div_quo),
        .out_payload (div_pay)
    );

    // ---- N7: restore signs, force a zero vector to zero
    dir_vec_t      out_dir_next;
    dir_vec_t      out_dir_reg;
    logic [PW-1:0] out_pay_reg;
    logic          out_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (div_pay.zero)
                out_dir_next[i] = '0;
            else if (div_pay.neg[i])
                out_dir_next[i] = FIELD_W'(-FIELD_W'(div_quo[i]));
            else
                out_dir_next[i] = FIELD_W'(div_quo[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dir_reg <= out_dir_next;
            out_pay_reg <= div_pay.user;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_dir     = out_dir_reg;
    assign out_payload = out_pay_reg;

endmodule
